// File: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared forms for the concurrent checks of the moisture filter.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that an implication holds at every clock edge outside of reset.
`define MFC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checks that a condition never holds outside of reset.
`define MFC_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// File: rtl/mfc_pkg.sv
// ---------------------------------------------------------------------------
// mfc_pkg
// Types, widths and constants shared by the moisture filter modules.
// ---------------------------------------------------------------------------
package mfc_pkg;

  localparam int RING_DEPTH = 8;

  localparam int LEVEL_W = 10;
  localparam int PCT_W   = 7;
  localparam int SLOT_W  = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int CNT_W   = $clog2(RING_DEPTH + 1);
  localparam int SUM_W   = LEVEL_W + CNT_W;

  // Dividend of the shared divider covers the ring sum and the scaled span.
  localparam int PCT_NUM_W = LEVEL_W + PCT_W;
  localparam int NUM_W     = (SUM_W > PCT_NUM_W) ? SUM_W : PCT_NUM_W;
  localparam int DEN_W     = LEVEL_W;
  localparam int STEP_W    = $clog2(NUM_W + 1);

  // A tenth of a 10-bit value is (x * 205) >> 11, exact up to 1028.
  localparam int MARGIN_MUL_W = 8;
  localparam int MARGIN_SHIFT = 11;
  localparam int MARGIN_W     = 7;
  localparam logic [MARGIN_MUL_W-1:0] MARGIN_MUL = 8'd205;

  localparam logic [LEVEL_W-1:0] DRY_RESET    = 10'd1000;
  localparam logic [LEVEL_W-1:0] WET_RESET    = 10'd300;
  localparam logic [PCT_W-1:0]   PERCENT_FULL = 7'd100;

  localparam int DATA_W = 32;
  localparam int ADDR_W = 4;

  typedef enum logic [1:0] {
    REG_DRY     = 2'd0,
    REG_WET     = 2'd1,
    REG_ANALOG  = 2'd2,
    REG_DIGITAL = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WRITE,
    ST_SUM,
    ST_MEAN,
    ST_SCALE,
    ST_PCT,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] adc_sample;
    logic               comparator_high;
  } sample_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] filtered_level;
    logic [PCT_W-1:0]   moisture_percent;
    logic               percent_present;
    logic               in_range;
    logic               soil_dry;
  } result_t;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] dividend;
    logic [DEN_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [NUM_W-1:0] quotient;
  } div_rsp_t;

endpackage

// File: rtl/mfc_ram.sv
// ---------------------------------------------------------------------------
// mfc_ram
// Generic single-port RAM with a registered read.
// ---------------------------------------------------------------------------
module mfc_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 8
) (
  input  logic                                         clk,
  input  logic                                         we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
  input  logic [WIDTH-1:0]                             wdata,
  output logic [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// File: rtl/mfc_div.sv
// ---------------------------------------------------------------------------
// mfc_div
// Restoring divider that produces one quotient bit per cycle.
// ---------------------------------------------------------------------------
module mfc_div (
  input  logic              clk,
  input  logic              rst,
  input  mfc_pkg::div_req_t req,
  output mfc_pkg::div_rsp_t rsp
);

  import mfc_pkg::*;

  logic              busy;
  logic              done;
  logic [STEP_W-1:0] step;
  logic [DEN_W-1:0]  rem;
  logic [NUM_W-1:0]  quo;
  logic [DEN_W-1:0]  den;

  logic [DEN_W:0]    shifted;
  logic              fits;
  logic [DEN_W:0]    diff;

  always_comb begin
    shifted = {rem, quo[NUM_W-1]};
    fits    = (shifted >= {1'b0, den});
    diff    = shifted - {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        step <= STEP_W'(NUM_W);
      end else if (busy) begin
        step <= step - 1'b1;
        if (step == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // The partial remainder stays below the divisor, so it fits in DEN_W bits.
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= '0;
      quo <= req.dividend;
      den <= req.divisor;
    end else if (busy) begin
      rem <= fits ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
      quo <= {quo[NUM_W-2:0], fits};
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

// File: rtl/moisture_filter_and_calibrate.sv
// With analog input, each accepted item is written to the ring; the ring entries are
// summed and divided by their count for the mean, then the scaled span is divided for
// the percent unless the mean is clamped. Both divisions use the shared divider in turn,
// one quotient bit per cycle each. No new item is taken until the result is loaded.
// Reset: synchronous; calibration registers return to 1000, 300, 1, 1 and the ring
// restarts empty, with no clearing pass since entries are read only after being written.
// ---------------------------------------------------------------------------
// moisture_filter_and_calibrate
// Ring-mean filter of soil samples with a linear, inverted percent calibration.
// ---------------------------------------------------------------------------
module moisture_filter_and_calibrate (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                sample_valid,
  output logic                                sample_stall,
  input  mfc_pkg::sample_t                    sample,
  output logic                                result_valid,
  input  logic                                result_stall,
  output mfc_pkg::result_t                    result,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [mfc_pkg::ADDR_W-1:0]          paddr,
  input  logic [mfc_pkg::DATA_W-1:0]          pwdata,
  output logic [mfc_pkg::DATA_W-1:0]          prdata,
  output logic                                pready
);

  import mfc_pkg::*;

  // Configuration registers.
  logic [LEVEL_W-1:0] dry_point;
  logic [LEVEL_W-1:0] wet_point;
  logic               analog_present;
  logic               digital_present;
  reg_idx_t           reg_idx;
  logic               cfg_write;

  // Sequencer and datapath registers.
  state_t             state;
  state_t             state_next;
  logic [LEVEL_W-1:0] adc;
  logic               soil_dry;
  logic [SLOT_W-1:0]  write_slot;
  logic               ring_full;
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   idx;
  logic [SUM_W-1:0]   acc;
  logic [LEVEL_W-1:0] level;
  logic [PCT_W-1:0]   pct;
  logic               present;
  logic               span_ok;
  logic [MARGIN_W-1:0] margin;

  // Combinational helpers.
  logic [CNT_W-1:0]   slot_inc;
  logic               slot_wrap;
  logic [SUM_W-1:0]   acc_sum;
  logic [LEVEL_W+MARGIN_MUL_W-1:0] margin_prod;
  logic [LEVEL_W:0]   level_lo;
  logic [LEVEL_W:0]   level_hi;
  logic               in_span;
  logic [PCT_NUM_W-1:0] pct_num;
  logic               accept;
  logic               load_result;

  logic               ram_we;
  logic [SLOT_W-1:0]  ram_addr;
  logic [LEVEL_W-1:0] ram_rdata;

  div_req_t           div_req;
  div_rsp_t           div_rsp;

  // ---------------- configuration port ----------------
  assign pready    = 1'b1;
  assign reg_idx   = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dry_point       <= DRY_RESET;
      wet_point       <= WET_RESET;
      analog_present  <= 1'b1;
      digital_present <= 1'b1;
    end else if (cfg_write) begin
      unique case (reg_idx)
        REG_DRY:     dry_point       <= pwdata[LEVEL_W-1:0];
        REG_WET:     wet_point       <= pwdata[LEVEL_W-1:0];
        REG_ANALOG:  analog_present  <= pwdata[0];
        REG_DIGITAL: digital_present <= pwdata[0];
        default:     ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_DRY:     prdata = DATA_W'(dry_point);
      REG_WET:     prdata = DATA_W'(wet_point);
      REG_ANALOG:  prdata = DATA_W'(analog_present);
      REG_DIGITAL: prdata = DATA_W'(digital_present);
      default:     prdata = '0;
    endcase
  end

  // ---------------- ring memory and divider ----------------
  assign ram_we   = (state == ST_WRITE);
  assign ram_addr = (state == ST_WRITE) ? write_slot : idx[SLOT_W-1:0];

  mfc_ram #(
    .WIDTH (LEVEL_W),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (adc),
    .rdata (ram_rdata)
  );

  mfc_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // ---------------- combinational datapath ----------------
  always_comb begin
    slot_inc    = CNT_W'(write_slot) + 1'b1;
    slot_wrap   = (slot_inc == CNT_W'(RING_DEPTH));
    acc_sum     = acc + SUM_W'(ram_rdata);
    margin_prod = (dry_point > wet_point) ?
                  (LEVEL_W + MARGIN_MUL_W)'(dry_point - wet_point) * MARGIN_MUL : '0;
    // The lower bound may go negative, so the margin moves to the level's side.
    level_lo    = {1'b0, level} + (LEVEL_W + 1)'(margin);
    level_hi    = {1'b0, dry_point} + (LEVEL_W + 1)'(margin);
    in_span     = (level_lo >= {1'b0, wet_point}) && ({1'b0, level} <= level_hi);
    pct_num     = PCT_NUM_W'(dry_point - level) * PCT_NUM_W'(PERCENT_FULL);
  end

  assign accept       = sample_valid && !sample_stall;
  assign sample_stall = (state != ST_IDLE);
  assign load_result  = (state == ST_FINISH) && (!result_valid || !result_stall);

  // ---------------- sequencer ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next       = state;
    div_req.start    = 1'b0;
    div_req.dividend = NUM_W'(acc_sum);
    div_req.divisor  = DEN_W'(count);
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = analog_present ? ST_WRITE : ST_FINISH;
        end
      end
      ST_WRITE: begin
        state_next = ST_SUM;
      end
      ST_SUM: begin
        if (idx == count) begin
          div_req.start = 1'b1;
          state_next    = ST_MEAN;
        end
      end
      ST_MEAN: begin
        if (div_rsp.done) begin
          state_next = ST_SCALE;
        end
      end
      ST_SCALE: begin
        if (level >= dry_point || level <= wet_point) begin
          state_next = ST_FINISH;
        end else begin
          div_req.start    = 1'b1;
          div_req.dividend = NUM_W'(pct_num);
          div_req.divisor  = dry_point - wet_point;
          state_next       = ST_PCT;
        end
      end
      ST_PCT: begin
        if (div_rsp.done) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (load_result) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Ring bookkeeping is control state; the rest is payload.
  always_ff @(posedge clk) begin
    if (rst) begin
      write_slot <= '0;
      ring_full  <= 1'b0;
    end else if (state == ST_WRITE) begin
      write_slot <= slot_wrap ? '0 : slot_inc[SLOT_W-1:0];
      if (slot_wrap) begin
        ring_full <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          adc      <= sample.adc_sample;
          soil_dry <= digital_present ? sample.comparator_high : 1'b1;
          level    <= '0;
          pct      <= '0;
          present  <= analog_present;
          span_ok  <= 1'b1;
        end
      end
      ST_WRITE: begin
        count  <= (ring_full || slot_wrap) ? CNT_W'(RING_DEPTH) : slot_inc;
        margin <= MARGIN_W'(margin_prod >> MARGIN_SHIFT);
        idx    <= '0;
        acc    <= '0;
      end
      ST_SUM: begin
        // Read data is registered, so it belongs to the address of the cycle before.
        idx <= idx + 1'b1;
        if (idx != '0) begin
          acc <= acc_sum;
        end
      end
      ST_MEAN: begin
        if (div_rsp.done) begin
          level <= div_rsp.quotient[LEVEL_W-1:0];
        end
      end
      ST_SCALE: begin
        span_ok <= in_span;
        if (level >= dry_point) begin
          pct <= '0;
        end else if (level <= wet_point) begin
          pct <= PERCENT_FULL;
        end
      end
      ST_PCT: begin
        if (div_rsp.done) begin
          pct <= div_rsp.quotient[PCT_W-1:0];
        end
      end
      default: ;
    endcase
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load_result) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_result) begin
      result.filtered_level   <= level;
      result.moisture_percent <= pct;
      result.percent_present  <= present;
      result.in_range         <= span_ok;
      result.soil_dry         <= soil_dry;
    end
  end

endmodule

// File: rtl/mfc_checker.sv
// ---------------------------------------------------------------------------
// mfc_checker
// Port-level checks of the moisture filter, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module mfc_checker (
  input logic             clk,
  input logic             rst,
  input logic             sample_valid,
  input logic             sample_stall,
  input logic             result_valid,
  input logic             result_stall,
  input mfc_pkg::result_t result
);

  import mfc_pkg::*;

  `MFC_ASSERT(a_result_held, result_valid && result_stall |=> result_valid, "result item dropped while stalled")
  `MFC_ASSERT(a_result_stable, result_valid && result_stall |=> $stable(result), "stalled result item changed")
  `MFC_ASSERT(a_busy_after_accept, sample_valid && !sample_stall |=> sample_stall, "second item taken during processing")
  `MFC_NEVER(a_percent_bound, result_valid && (result.moisture_percent > PERCENT_FULL), "moisture percent above full scale")
  `MFC_NEVER(a_no_analog, result_valid && !result.percent_present && ((result.filtered_level != '0) || (result.moisture_percent != '0) || !result.in_range), "result without analog input is not neutral")

endmodule

bind moisture_filter_and_calibrate mfc_checker u_mfc_checker (
  .clk          (clk),
  .rst          (rst),
  .sample_valid (sample_valid),
  .sample_stall (sample_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);
